// ===== hdl/crxfifo_pkg.sv =====
// Shared types and constants for the console receive FIFO with break scan.
// No dependencies; every other file of the block imports this package.
package crxfifo_pkg;

  localparam int unsigned RingDepthDef = 1024;

  localparam int unsigned OpW      = 2;
  localparam int unsigned DataW    = 8;
  localparam int unsigned SrcSeenW = 2;

  localparam logic [OpW-1:0] OP_PUT   = 2'd0;
  localparam logic [OpW-1:0] OP_GET   = 2'd1;
  localparam logic [OpW-1:0] OP_BREAK = 2'd2;

  localparam logic [SrcSeenW-1:0] SRC_NONE = 2'd0;
  localparam logic [SrcSeenW-1:0] SRC_UART = 2'd1;
  localparam logic [SrcSeenW-1:0] SRC_USB  = 2'd2;

  localparam logic [DataW-1:0] BREAK_CHAR_RESET = 8'h03;

  // what a commit does to the ring state and the result word
  typedef enum logic [1:0] {
    RES_PLAIN,
    RES_PUT,
    RES_GET,
    RES_BREAK
  } res_kind_e;

  typedef struct packed {
    logic      latch;      // capture the accepted input word
    logic      rd_en;      // ring read, data registered
    logic      rd_cur;     // read address: 1 scan cursor, 0 read pointer
    logic      cur_load;   // cursor <= read pointer
    logic      cur_adv;    // cursor <= next(cursor)
    logic      commit_en;  // update state and load the output register
    res_kind_e kind;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic           empty;     // read pointer == write pointer
    logic           scan_end;  // cursor == write pointer
    logic           match;     // registered ring data == break char
    logic           out_free;  // output register can take a word
  } dp_status_t;

endpackage

// ===== hdl/crxfifo_if.sv =====
// Handshake channels of the console receive FIFO: input, output, config.
// Depends on crxfifo_pkg for field widths.
interface crxfifo_in_if
  import crxfifo_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OpW-1:0]   op;
  logic [DataW-1:0] data_in;
  logic             source;

  modport src (output valid, output op, output data_in, output source, input ready);
  modport snk (input valid, input op, input data_in, input source, output ready);
endinterface

interface crxfifo_out_if
  import crxfifo_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [DataW-1:0]    data_out;
  logic                got_byte;
  logic                overflow;
  logic                break_found;
  logic [SrcSeenW-1:0] last_source;
  logic                console_active;

  modport src (output valid, output data_out, output got_byte, output overflow,
               output break_found, output last_source, output console_active,
               input ready);
  modport snk (input valid, input data_out, input got_byte, input overflow,
               input break_found, input last_source, input console_active,
               output ready);
endinterface

interface crxfifo_cfg_if
  import crxfifo_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data;

  modport src (output valid, output data, input ready);
  modport snk (input valid, input data, output ready);
endinterface

// ===== hdl/console_rx_fifo_with_break_scan_top.sv =====
// Top level of the console receive FIFO with break scan.
// Depends on crxfifo_pkg, crxfifo_if, crxfifo_ctrl and crxfifo_dp.
//
//   channel  dir  handshake      word
//   in_i     in   valid/ready    op, data_in, source
//   out_o    out  valid/ready    data_out, got_byte, overflow, break_found,
//                                last_source, console_active
//   cfg_i    in   valid/ready    data (break char), ready always high
//
// Put, unused op and get on an empty ring: accept in idle, commit from the exec state.
// Get with data: exec reads the ring, a wait state commits; the read port is registered.
// Break check: a check and a compare state per entry; a hit commits from compare.
// Reset clears pointers and flags; the ring itself gets no clearing pass.
// One word in flight; a new word is taken while a result waits at the output,
// and its commit holds until the output register is free.
module console_rx_fifo_with_break_scan_top
  import crxfifo_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RingDepthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  crxfifo_in_if.snk  in_i,
  crxfifo_out_if.src out_o,
  crxfifo_cfg_if.snk cfg_i
);

  ctrl_cmd_t  cmd;
  dp_status_t sts;
  logic       in_ready;

  assign in_i.ready = in_ready;

  crxfifo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  crxfifo_dp #(
    .RING_DEPTH (RING_DEPTH)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .op_i      (in_i.op),
    .data_in_i (in_i.data_in),
    .source_i  (in_i.source),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_o     (out_o),
    .cfg_i     (cfg_i)
  );

  // a commit must never overwrite a result that is still waiting
  a_commit_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit_en |-> sts.out_free)
    else $error("commit while output register busy");

  // one word at a time: no accept right after an accept
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while previous word in flight");

  a_commit_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit_en |=> out_o.valid)
    else $error("commit did not produce a result word");

  a_read_not_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.rd_en && cmd.commit_en))
    else $error("ring read and commit in the same cycle");

endmodule

// ===== hdl/crxfifo_ctrl.sv =====
// Sequencer of the console receive FIFO: dispatch, ring read, break scan.
// Depends on crxfifo_pkg; drives the command struct of crxfifo_dp.
module crxfifo_ctrl
  import crxfifo_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t sts_i,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_GET_WAIT,
    ST_SCAN_CHK,
    ST_SCAN_CMP
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.kind = RES_PLAIN;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts_i.op)
          OP_PUT: begin
            if (sts_i.out_free) begin
              cmd_o.commit_en = 1'b1;
              cmd_o.kind      = RES_PUT;
              state_d         = ST_IDLE;
            end
          end
          OP_GET: begin
            if (sts_i.empty) begin
              if (sts_i.out_free) begin
                cmd_o.commit_en = 1'b1;
                state_d         = ST_IDLE;
              end
            end else begin
              cmd_o.rd_en = 1'b1;
              state_d     = ST_GET_WAIT;
            end
          end
          OP_BREAK: begin
            cmd_o.cur_load = 1'b1;
            state_d        = ST_SCAN_CHK;
          end
          default: begin
            if (sts_i.out_free) begin
              cmd_o.commit_en = 1'b1;
              state_d         = ST_IDLE;
            end
          end
        endcase
      end
      ST_GET_WAIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit_en = 1'b1;
          cmd_o.kind      = RES_GET;
          state_d         = ST_IDLE;
        end
      end
      ST_SCAN_CHK: begin
        if (sts_i.scan_end) begin
          if (sts_i.out_free) begin
            cmd_o.commit_en = 1'b1;
            state_d         = ST_IDLE;
          end
        end else begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_cur = 1'b1;
          state_d      = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        // on a hit, read data and cursor hold until the output frees up
        if (sts_i.match) begin
          if (sts_i.out_free) begin
            cmd_o.commit_en = 1'b1;
            cmd_o.kind      = RES_BREAK;
            state_d         = ST_IDLE;
          end
        end else begin
          cmd_o.cur_adv = 1'b1;
          state_d       = ST_SCAN_CHK;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/crxfifo_dp.sv =====
// Datapath of the console receive FIFO: ring memory, pointers, flags,
// break char register and output register. Depends on crxfifo_pkg, crxfifo_if.
module crxfifo_dp
  import crxfifo_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RingDepthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [OpW-1:0]   op_i,
  input  logic [DataW-1:0] data_in_i,
  input  logic             source_i,
  input  ctrl_cmd_t        cmd_i,
  output dp_status_t       sts_o,
  crxfifo_out_if.src       out_o,
  crxfifo_cfg_if.snk       cfg_i
);

  localparam int unsigned PtrW = $clog2(RING_DEPTH);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(RING_DEPTH - 1);

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    if (p == LastIdx) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  logic [DataW-1:0] ring_q [RING_DEPTH];
  logic [DataW-1:0] rdata_q;
  logic [PtrW-1:0]  rd_addr;
  logic             ring_we;

  logic [OpW-1:0]   op_q;
  logic [DataW-1:0] data_q;
  logic             src_q;

  logic [PtrW-1:0]     wptr_q, wptr_d;
  logic [PtrW-1:0]     rptr_q, rptr_d;
  logic [PtrW-1:0]     cur_q;
  logic [SrcSeenW-1:0] src_seen_q, src_seen_d;
  logic                active_q, active_d;
  logic [DataW-1:0]    brk_char_q;
  logic                full;

  logic [DataW-1:0]    res_data;
  logic                res_got, res_ovf, res_brk;

  logic                out_valid_q;
  logic [DataW-1:0]    out_data_q;
  logic                out_got_q, out_ovf_q, out_brk_q;
  logic [SrcSeenW-1:0] out_src_q;
  logic                out_active_q;

  assign full    = (ptr_next(wptr_q) == rptr_q);
  assign rd_addr = cmd_i.rd_cur ? cur_q : rptr_q;
  assign ring_we = cmd_i.commit_en && (cmd_i.kind == RES_PUT) && !full;

  assign sts_o.op       = op_q;
  assign sts_o.empty    = (rptr_q == wptr_q);
  assign sts_o.scan_end = (cur_q == wptr_q);
  assign sts_o.match    = (rdata_q == brk_char_q);
  assign sts_o.out_free = !out_valid_q || out_o.ready;

  // next state and result word of a commit
  always_comb begin
    wptr_d     = wptr_q;
    rptr_d     = rptr_q;
    src_seen_d = src_seen_q;
    active_d   = active_q;
    res_data   = '0;
    res_got    = 1'b0;
    res_ovf    = 1'b0;
    res_brk    = 1'b0;
    if (cmd_i.commit_en) begin
      case (cmd_i.kind)
        RES_PUT: begin
          res_ovf = full;
          if (!full) begin
            wptr_d = ptr_next(wptr_q);
          end
          src_seen_d = src_q ? SRC_USB : SRC_UART;
        end
        RES_GET: begin
          rptr_d   = ptr_next(rptr_q);
          active_d = 1'b1;
          res_data = rdata_q;
          res_got  = 1'b1;
        end
        RES_BREAK: begin
          // drop everything up to and including the break byte
          rptr_d  = ptr_next(cur_q);
          res_brk = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_q[wptr_q] <= data_q;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= ring_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= op_i;
      data_q <= data_in_i;
      src_q  <= source_i;
    end
    if (cmd_i.commit_en) begin
      out_data_q   <= res_data;
      out_got_q    <= res_got;
      out_ovf_q    <= res_ovf;
      out_brk_q    <= res_brk;
      out_src_q    <= src_seen_d;
      out_active_q <= active_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q      <= '0;
      rptr_q      <= '0;
      cur_q       <= '0;
      src_seen_q  <= SRC_NONE;
      active_q    <= 1'b0;
      brk_char_q  <= BREAK_CHAR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      wptr_q     <= wptr_d;
      rptr_q     <= rptr_d;
      src_seen_q <= src_seen_d;
      active_q   <= active_d;
      if (cmd_i.cur_load) begin
        cur_q <= rptr_q;
      end else if (cmd_i.cur_adv) begin
        cur_q <= ptr_next(cur_q);
      end
      if (cfg_i.valid) begin
        brk_char_q <= cfg_i.data;
      end
      if (cmd_i.commit_en) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign cfg_i.ready = 1'b1;

  assign out_o.valid          = out_valid_q;
  assign out_o.data_out       = out_data_q;
  assign out_o.got_byte       = out_got_q;
  assign out_o.overflow       = out_ovf_q;
  assign out_o.break_found    = out_brk_q;
  assign out_o.last_source    = out_src_q;
  assign out_o.console_active = out_active_q;

endmodule
